[hw/rtl/gpl_pkg.sv]
// gpl_pkg: shared types, codes and sizing constants for the gpu power level policy
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package gpl_pkg;

    localparam int LEVEL_COUNT = 5;
    localparam int TIMER_BITS  = 16;
    localparam int RULE_REGS   = 5;
    localparam int SCAN_LEVELS = (LEVEL_COUNT < RULE_REGS) ? LEVEL_COUNT : RULE_REGS;

    localparam int LEVEL_W   = 3;
    localparam int RULE_W    = 10;
    localparam int THRESH_W  = 8;
    localparam int WATTS_W   = 8;
    localparam int PERCENT_W = 7;
    localparam int TICKS_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVEL_COUNT - 1);
    localparam logic [TICKS_W-1:0] RELEASE_TICKS_RST = TICKS_W'(1000);

    typedef enum logic [1:0] {
        OP_EVALUATE     = 2'd0,
        OP_THROTTLE_ON  = 2'd1,
        OP_THROTTLE_OFF = 2'd2,
        OP_TICK         = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_AC   = 2'd1,
        SRC_DC   = 2'd2,
        SRC_ACDC = 2'd3
    } src_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY0        = 3'd0,
        REG_ENTRY1        = 3'd1,
        REG_ENTRY2        = 3'd2,
        REG_ENTRY3        = 3'd3,
        REG_ENTRY4        = 3'd4,
        REG_RULES_VALID   = 3'd5,
        REG_RELEASE_TICKS = 3'd6,
        REG_UNUSED        = 3'd7
    } reg_idx_t;

    typedef struct packed {
        src_t                source;
        logic [THRESH_W-1:0] threshold;
    } rule_t;

    typedef rule_t [RULE_REGS-1:0] rule_table_t;

    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] level;
    } pick_t;

endpackage

[hw/rtl/gpu_power_level_policy.sv]
// gpu_power_level_policy: top level, config registers, level and throttle state
// depends on gpl_pkg and gpl_select
`timescale 1ns / 1ps

// One item per clock: each accepted transfer is decoded and matched against the five
// rules and the release timer combinationally, and its result is registered in the
// output register, so the result appears in the cycle after the item. The
// input is ready whenever the output register is empty or is being taken in the
// same cycle; a stalled output holds further items. Configuration writes are
// taken every cycle and must only be issued while the block is idle.
module gpu_power_level_policy (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic                             system_on,
    input  logic                             external_power,
    input  logic [gpl_pkg::WATTS_W-1:0]      charger_watts,
    input  logic [gpl_pkg::PERCENT_W-1:0]    battery_percent,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gpl_pkg::LEVEL_W-1:0]      gpu_level,
    output logic                             throttle_released,
    output logic                             level_changed,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gpl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    gpl_pkg::rule_table_t               rules_reg;
    logic                               rules_valid_reg;
    logic [gpl_pkg::TICKS_W-1:0]        release_ticks_reg;

    logic [gpl_pkg::LEVEL_W-1:0]        level_reg, level_next;
    logic                               throttle_reg, throttle_next;
    logic [gpl_pkg::TIMER_BITS-1:0]     count_reg, count_next;
    logic                               pending_reg, pending_next;
    logic                               changed_reg, changed_next;
    logic                               out_valid_reg;

    gpl_pkg::pick_t                     pick;
    logic                               in_fire;
    logic                               do_eval;

    gpl_select u_select (
        .rules           (rules_reg),
        .external_power  (external_power),
        .charger_watts   (charger_watts),
        .battery_percent (battery_percent),
        .pick            (pick)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        level_next    = level_reg;
        throttle_next = throttle_reg;
        count_next    = count_reg;
        pending_next  = pending_reg;
        do_eval       = 1'b0;
        case (gpl_pkg::op_t'(operation))
            gpl_pkg::OP_EVALUATE:
            begin
                do_eval = 1'b1;
            end
            gpl_pkg::OP_THROTTLE_ON:
            begin
                throttle_next = 1'b0;
                level_next    = gpl_pkg::TOP_LEVEL;
                count_next    = gpl_pkg::TIMER_BITS'(release_ticks_reg);
                pending_next  = 1'b1;
            end
            gpl_pkg::OP_THROTTLE_OFF:
            begin
                throttle_next = 1'b1;
                do_eval       = 1'b1;
            end
            default:
            begin
                if (pending_reg)
                begin
                    // expiry on the tick that finds the count at one or zero
                    if (count_reg <= gpl_pkg::TIMER_BITS'(1))
                    begin
                        count_next    = '0;
                        pending_next  = 1'b0;
                        throttle_next = 1'b1;
                        do_eval       = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - gpl_pkg::TIMER_BITS'(1);
                    end
                end
            end
        endcase
        if (do_eval && system_on && rules_valid_reg && pick.hit)
        begin
            level_next = pick.level;
        end
        changed_next = (level_next != level_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_reg         <= '0;
            rules_valid_reg   <= 1'b0;
            release_ticks_reg <= gpl_pkg::RELEASE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gpl_pkg::reg_idx_t'(cfg_index))
                gpl_pkg::REG_ENTRY0,
                gpl_pkg::REG_ENTRY1,
                gpl_pkg::REG_ENTRY2,
                gpl_pkg::REG_ENTRY3,
                gpl_pkg::REG_ENTRY4:
                begin
                    rules_reg[cfg_index] <= gpl_pkg::rule_t'(cfg_data[gpl_pkg::RULE_W-1:0]);
                end
                gpl_pkg::REG_RULES_VALID:
                begin
                    rules_valid_reg <= cfg_data[0];
                end
                gpl_pkg::REG_RELEASE_TICKS:
                begin
                    release_ticks_reg <= cfg_data[gpl_pkg::TICKS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            throttle_reg  <= 1'b1;
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                level_reg    <= level_next;
                throttle_reg <= throttle_next;
                count_reg    <= count_next;
                pending_reg  <= pending_next;
                changed_reg  <= changed_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign gpu_level         = level_reg;
    assign throttle_released = throttle_reg;
    assign level_changed     = changed_reg;

endmodule

[hw/rtl/gpl_select.sv]
// gpl_select: priority pick of the policy level from the rule table
// depends on gpl_pkg
`timescale 1ns / 1ps

module gpl_select (
    input  gpl_pkg::rule_table_t            rules,
    input  logic                            external_power,
    input  logic [gpl_pkg::WATTS_W-1:0]     charger_watts,
    input  logic [gpl_pkg::PERCENT_W-1:0]   battery_percent,
    output gpl_pkg::pick_t                  pick
);

    logic [gpl_pkg::SCAN_LEVELS-1:0] match;

    always_comb
    begin
        for (int i = 0; i < gpl_pkg::SCAN_LEVELS; i++)
        begin
            if (external_power)
            begin
                match[i] = (rules[i].source == gpl_pkg::SRC_ACDC) ||
                           ((rules[i].source == gpl_pkg::SRC_AC) &&
                            (charger_watts >= rules[i].threshold));
            end
            else
            begin
                match[i] = (rules[i].source == gpl_pkg::SRC_ACDC) ||
                           ((rules[i].source == gpl_pkg::SRC_DC) &&
                            ({1'b0, battery_percent} <= rules[i].threshold));
            end
        end
    end

    // ac takes the lowest matching level, battery the highest
    always_comb
    begin
        pick = '0;
        if (external_power)
        begin
            for (int i = gpl_pkg::SCAN_LEVELS - 1; i >= 0; i--)
            begin
                if (match[i])
                begin
                    pick.hit   = 1'b1;
                    pick.level = gpl_pkg::LEVEL_W'(i);
                end
            end
        end
        else
        begin
            for (int i = 0; i < gpl_pkg::SCAN_LEVELS; i++)
            begin
                if (match[i])
                begin
                    pick.hit   = 1'b1;
                    pick.level = gpl_pkg::LEVEL_W'(i);
                end
            end
        end
    end

endmodule

[hw/rtl/gpl_checker.sv]
// gpl_checker: port-level assertions for gpu_power_level_policy, bound to the top
// depends on gpl_pkg and gpu_power_level_policy
`timescale 1ns / 1ps

module gpl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [1:0]                       operation,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [gpl_pkg::LEVEL_W-1:0]      gpu_level,
    input logic                             throttle_released
);

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // level never leaves the table
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gpu_level <= gpl_pkg::TOP_LEVEL))
        else $error("gpu level out of range");

    // throttle-on transfer yields throttled line at the top level
    a_throttle_on: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == gpl_pkg::OP_THROTTLE_ON)) |=>
            (out_valid && !throttle_released && (gpu_level == gpl_pkg::TOP_LEVEL)))
        else $error("throttle-on result wrong");

    // throttle-off transfer always releases the line
    a_throttle_off: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == gpl_pkg::OP_THROTTLE_OFF)) |=>
            (out_valid && throttle_released))
        else $error("throttle-off did not release");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(gpu_level) && $stable(throttle_released)))
        else $error("stalled result changed");

endmodule

bind gpu_power_level_policy gpl_checker u_gpl_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .gpu_level         (gpu_level),
    .throttle_released (throttle_released)
);

[test/gpl_level_checker.sv]
// gpl_level_checker: predicts each result of the gpu power level policy and compares it
// watches the input, output and config channels; depends on gpl_pkg
`timescale 1ns / 1ps

module gpl_level_checker
    import gpl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [1:0]             operation,
    input  logic                   system_on,
    input  logic                   external_power,
    input  logic [WATTS_W-1:0]     charger_watts,
    input  logic [PERCENT_W-1:0]   battery_percent,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [LEVEL_W-1:0]     gpu_level,
    input  logic                   throttle_released,
    input  logic                   level_changed,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     outstanding
);

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               released;
        logic               changed;
    } report_t;

    rule_t                 rule_tab [RULE_REGS];
    logic                  rules_on;
    logic [TICKS_W-1:0]    rel_ticks;
    logic [LEVEL_W-1:0]    cur_level;
    logic                  line_up;
    logic [TIMER_BITS-1:0] timer_count;
    logic                  timer_armed;
    report_t               level_reports [$];

    initial fail_count = 0;
    initial outstanding = 0;

    // policy pick, current level kept when no rule matches
    function automatic logic [LEVEL_W-1:0] choose_level(
        input logic                 ext,
        input logic [WATTS_W-1:0]   watts,
        input logic [PERCENT_W-1:0] pct
    );
        logic [LEVEL_W-1:0] pick;
        logic               found;
        pick  = cur_level;
        found = 1'b0;
        if (ext)
        begin
            for (int lv = 0; lv < LEVEL_COUNT; lv++)
            begin
                if (!found && lv < RULE_REGS)
                begin
                    if ((rule_tab[lv].source == SRC_AC && watts >= rule_tab[lv].threshold)
                        || rule_tab[lv].source == SRC_ACDC)
                    begin
                        pick  = LEVEL_W'(lv);
                        found = 1'b1;
                    end
                end
            end
        end
        else
        begin
            for (int lv = LEVEL_COUNT - 1; lv >= 0; lv--)
            begin
                if (!found && lv < RULE_REGS)
                begin
                    if ((rule_tab[lv].source == SRC_DC && pct <= rule_tab[lv].threshold)
                        || rule_tab[lv].source == SRC_ACDC)
                    begin
                        pick  = LEVEL_W'(lv);
                        found = 1'b1;
                    end
                end
            end
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        report_t            got;
        report_t            want;
        logic [LEVEL_W-1:0] nxt;
        if (!rst_n)
        begin
            for (int i = 0; i < RULE_REGS; i++)
                rule_tab[i] = '0;
            rules_on    = 1'b0;
            rel_ticks   = RELEASE_TICKS_RST;
            cur_level   = '0;
            line_up     = 1'b1;
            timer_count = '0;
            timer_armed = 1'b0;
            level_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            // result transfer first, it belongs to an older item
            if (out_valid && out_ready)
            begin
                got = '{gpu_level, throttle_released, level_changed};
                if (level_reports.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual level %0d released %0b changed %0b",
                             $time, got.level, got.released, got.changed);
                    fail_count++;
                end
                else
                begin
                    want = level_reports.pop_front();
                    if (got.level !== want.level)
                    begin
                        $display("%0t gpu_level mismatch: expected %0d actual %0d",
                                 $time, want.level, got.level);
                        fail_count++;
                    end
                    if (got.released !== want.released)
                    begin
                        $display("%0t throttle_released mismatch: expected %0b actual %0b",
                                 $time, want.released, got.released);
                        fail_count++;
                    end
                    if (got.changed !== want.changed)
                    begin
                        $display("%0t level_changed mismatch: expected %0b actual %0b",
                                 $time, want.changed, got.changed);
                        fail_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENTRY0, REG_ENTRY1, REG_ENTRY2, REG_ENTRY3, REG_ENTRY4:
                        rule_tab[cfg_index] = cfg_data[RULE_W-1:0];
                    REG_RULES_VALID:
                        rules_on = cfg_data[0];
                    REG_RELEASE_TICKS:
                        rel_ticks = cfg_data[TICKS_W-1:0];
                    default:
                        ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                nxt = cur_level;
                case (operation)
                    OP_EVALUATE:
                    begin
                        if (system_on && rules_on)
                            nxt = choose_level(external_power, charger_watts, battery_percent);
                    end
                    OP_THROTTLE_ON:
                    begin
                        line_up     = 1'b0;
                        nxt         = TOP_LEVEL;
                        timer_count = TIMER_BITS'(rel_ticks);
                        timer_armed = 1'b1;
                    end
                    OP_THROTTLE_OFF:
                    begin
                        line_up = 1'b1;
                        if (system_on && rules_on)
                            nxt = choose_level(external_power, charger_watts, battery_percent);
                    end
                    default:
                    begin
                        if (timer_armed)
                        begin
                            if (timer_count <= 1)
                            begin
                                timer_count = '0;
                                timer_armed = 1'b0;
                                line_up     = 1'b1;
                                if (system_on && rules_on)
                                    nxt = choose_level(external_power, charger_watts,
                                                       battery_percent);
                            end
                            else
                                timer_count = timer_count - 1'b1;
                        end
                    end
                endcase
                want.changed  = (nxt != cur_level);
                cur_level     = nxt;
                want.level    = cur_level;
                want.released = line_up;
                level_reports.push_back(want);
            end
            outstanding <= level_reports.size();
        end
    end

endmodule

[test/gpu_power_level_policy_tb.sv]
// gpu_power_level_policy_tb: stimulus and verdict for the gpu power level policy
// drives the block and gpl_level_checker side by side; depends on gpl_pkg
`timescale 1ns / 1ps

module gpu_power_level_policy_tb;
    import gpl_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 105;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             operation = OP_EVALUATE;
    logic                   system_on = 1'b0;
    logic                   external_power = 1'b0;
    logic [WATTS_W-1:0]     charger_watts = '0;
    logic [PERCENT_W-1:0]   battery_percent = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [LEVEL_W-1:0]     gpu_level;
    logic                   throttle_released;
    logic                   level_changed;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_ENTRY0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     fail_count;
    int                     outstanding;
    int                     items_sent = 0;
    int                     cycles = 0;
    logic                   calm = 1'b0;
    logic [TICKS_W-1:0]     cur_ticks = RELEASE_TICKS_RST;

    gpu_power_level_policy DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .system_on         (system_on),
        .external_power    (external_power),
        .charger_watts     (charger_watts),
        .battery_percent   (battery_percent),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .gpu_level         (gpu_level),
        .throttle_released (throttle_released),
        .level_changed     (level_changed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    gpl_level_checker level_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .system_on         (system_on),
        .external_power    (external_power),
        .charger_watts     (charger_watts),
        .battery_percent   (battery_percent),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .gpu_level         (gpu_level),
        .throttle_released (throttle_released),
        .level_changed     (level_changed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic put_item(input op_t op, input logic on, input logic ext,
                            input logic [WATTS_W-1:0] watts,
                            input logic [PERCENT_W-1:0] pct);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        system_on       <= on;
        external_power  <= ext;
        charger_watts   <= watts;
        battery_percent <= pct;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_RELEASE_TICKS)
            cur_ticks = data;
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // every item yields one result, so an empty queue means the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic load_rules(input src_t s0, input logic [7:0] t0,
                              input src_t s1, input logic [7:0] t1,
                              input src_t s2, input logic [7:0] t2,
                              input src_t s3, input logic [7:0] t3,
                              input src_t s4, input logic [7:0] t4);
        write_reg(REG_ENTRY0, {6'd0, s0, t0});
        write_reg(REG_ENTRY1, {6'd0, s1, t1});
        write_reg(REG_ENTRY2, {6'd0, s2, t2});
        write_reg(REG_ENTRY3, {6'd0, s3, t3});
        write_reg(REG_ENTRY4, {6'd0, s4, t4});
    endtask

    task automatic random_item(input op_t op);
        logic [WATTS_W-1:0]   watts;
        logic [PERCENT_W-1:0] pct;
        case ($urandom_range(0, 5))
            0:       watts = '0;
            1:       watts = '1;
            default: watts = WATTS_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 9) == 0)
            pct = PERCENT_W'($urandom_range(101, 127));
        else
            pct = PERCENT_W'($urandom_range(0, 100));
        put_item(op, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), watts, pct);
    endtask

    task automatic random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            random_item(OP_EVALUATE);
        else if (r < 45)
            random_item(OP_THROTTLE_ON);
        else if (r < 58)
            random_item(OP_THROTTLE_OFF);
        else
            random_item(OP_TICK);
    endtask

    // throttle-on then a run of ticks toward expiry, with evaluates and throttle-offs mixed in
    task automatic throttle_episode();
        int n;
        n = (cur_ticks > 20) ? 20 : int'(cur_ticks) + int'($urandom_range(0, 3));
        random_item(OP_THROTTLE_ON);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0:       random_item(OP_EVALUATE);
                1:       random_item(OP_THROTTLE_OFF);
                default: random_item(OP_TICK);
            endcase
        end
    endtask

    task automatic random_setup();
        logic [TICKS_W-1:0] ticks;
        logic [7:0]         thr;
        for (int i = 0; i < RULE_REGS; i++)
        begin
            case ($urandom_range(0, 4))
                0:       thr = 8'h00;
                1:       thr = 8'hFF;
                default: thr = 8'($urandom_range(0, 255));
            endcase
            write_reg(reg_idx_t'(i), {6'd0, 2'($urandom_range(0, 3)), thr});
        end
        write_reg(REG_RULES_VALID, {15'd0, 1'($urandom_range(0, 5) != 0)});
        case ($urandom_range(0, 9))
            0:       ticks = '1;
            1:       ticks = '0;
            2:       ticks = 16'd1;
            default: ticks = TICKS_W'($urandom_range(2, 12));
        endcase
        write_reg(REG_RELEASE_TICKS, ticks);
        end_writes();
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: table invalid, long release
        put_item(OP_EVALUATE, 1'b1, 1'b1, 8'hFF, 7'd50);
        put_item(OP_THROTTLE_ON, 1'b1, 1'b1, 8'hFF, 7'd50);
        put_item(OP_TICK, 1'b1, 1'b1, 8'hFF, 7'd50);
        put_item(OP_THROTTLE_OFF, 1'b1, 1'b1, 8'hFF, 7'd50);
        drain();

        load_rules(SRC_AC, 8'd200, SRC_AC, 8'd60, SRC_ACDC, 8'd0,
                   SRC_DC, 8'd30, SRC_DC, 8'd5);
        write_reg(REG_RULES_VALID, 16'd1);
        write_reg(REG_RELEASE_TICKS, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        end_writes();
        put_item(OP_EVALUATE, 1'b1, 1'b1, 8'hFF, 7'd0);
        put_item(OP_EVALUATE, 1'b1, 1'b1, 8'h00, 7'd0);
        put_item(OP_EVALUATE, 1'b1, 1'b1, 8'd60, 7'd0);
        put_item(OP_EVALUATE, 1'b1, 1'b0, 8'h00, 7'd0);
        put_item(OP_EVALUATE, 1'b1, 1'b0, 8'hFF, 7'd127);
        put_item(OP_EVALUATE, 1'b1, 1'b0, 8'h00, 7'd30);
        put_item(OP_EVALUATE, 1'b0, 1'b1, 8'hFF, 7'd0);
        // zero release ticks: first tick expires
        put_item(OP_THROTTLE_ON, 1'b1, 1'b0, 8'h00, 7'd100);
        put_item(OP_TICK, 1'b1, 1'b0, 8'h00, 7'd100);
        put_item(OP_TICK, 1'b1, 1'b1, 8'hFF, 7'd100);
        drain();

        write_reg(REG_RELEASE_TICKS, 16'd2);
        end_writes();
        put_item(OP_THROTTLE_ON, 1'b1, 1'b1, 8'hFF, 7'd0);
        put_item(OP_THROTTLE_OFF, 1'b1, 1'b1, 8'hFF, 7'd0);
        put_item(OP_TICK, 1'b1, 1'b1, 8'd60, 7'd0);
        put_item(OP_THROTTLE_ON, 1'b1, 1'b1, 8'd60, 7'd0);
        put_item(OP_TICK, 1'b1, 1'b1, 8'd60, 7'd0);
        put_item(OP_TICK, 1'b1, 1'b1, 8'd60, 7'd0);
        drain();

        // no rule can match
        load_rules(SRC_NONE, 8'hFF, SRC_NONE, 8'hFF, SRC_NONE, 8'hFF,
                   SRC_NONE, 8'hFF, SRC_NONE, 8'hFF);
        write_reg(REG_RELEASE_TICKS, 16'hFFFF);
        end_writes();
        put_item(OP_EVALUATE, 1'b1, 1'b1, 8'hFF, 7'd0);
        put_item(OP_EVALUATE, 1'b1, 1'b0, 8'h00, 7'd0);
        put_item(OP_THROTTLE_ON, 1'b1, 1'b0, 8'h00, 7'd0);
        put_item(OP_TICK, 1'b1, 1'b0, 8'h00, 7'd0);
        put_item(OP_THROTTLE_OFF, 1'b1, 1'b0, 8'h00, 7'd0);
        drain();

        write_reg(REG_RULES_VALID, 16'd0);
        write_reg(REG_RELEASE_TICKS, 16'd1);
        end_writes();
        put_item(OP_THROTTLE_ON, 1'b1, 1'b1, 8'hFF, 7'd0);
        put_item(OP_TICK, 1'b1, 1'b1, 8'hFF, 7'd0);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            random_setup();
            if (ph == 7)
                calm = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    throttle_episode();
                else
                    random_op();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/gpl_pkg.sv
hw/rtl/gpl_select.sv
hw/rtl/gpu_power_level_policy.sv
hw/rtl/gpl_checker.sv
test/gpl_level_checker.sv
test/gpu_power_level_policy_tb.sv
